// ----- src/cpsb_pkg.sv -----
package cpsb_pkg;

   localparam int SCREEN_W_DEF = 320;
   localparam int SCREEN_H_DEF = 200;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_COLUMN = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ = 3'd3;
   localparam logic [2:0] OP_TINT = 3'd4;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_BAD = 2'd2;

   localparam logic [1:0] MODE_OPAQUE = 2'd0;
   localparam logic [1:0] MODE_TRANS = 2'd1;
   localparam logic [1:0] MODE_SHADOW = 2'd2;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TOP = 3'd1;
   localparam logic [2:0] PH_LEN = 3'd2;
   localparam logic [2:0] PH_PADA = 3'd3;
   localparam logic [2:0] PH_PIX = 3'd4;
   localparam logic [2:0] PH_PADB = 3'd5;

   localparam logic [7:0] END_MARK = 8'hff;

   typedef struct packed {
      logic [2:0] op;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] left_offset;
      logic signed [15:0] top_offset;
      logic [14:0] patch_width;
      logic [14:0] patch_height;
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] pixel_address;
      logic [7:0] pixel_value;
      logic last;
   } rsp_type;

endpackage

// ----- src/cpsb_if.sv -----
interface cpsb_req_if;
   logic valid;
   logic ready;
   cpsb_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cpsb_rsp_if;
   logic valid;
   logic ready;
   cpsb_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/cpsb_fifo.sv -----
module cpsb_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cpsb_pkg::rsp_type push_data,
   output logic [2:0] count,
   cpsb_rsp_if.source rsp
);
   cpsb_pkg::rsp_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic pop;

   assign pop = rsp.valid && rsp.ready;
   assign rsp.valid = cnt_ff != 3'd0;
   assign rsp.data = mem_ff[rp_ff];
   assign count = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end
endmodule

// ----- src/column_post_sprite_blitter.sv -----
// Column-post sprite blitter. Requests go through a small sequencer around
// a framebuffer memory and a tint memory, both single-ported with registered
// reads. Plain writes, tint loads, stream control bytes and opaque pixels are
// handled in the accept state. Reads and start requests go on to a further
// state (for a start, the bounds check). Translucent pixels go through read,
// tint lookup, write. Shadowed pixels whose shadow lands on screen go through
// shadow read, shadow tint, shadow write, then the copy write. Results queue in
// a four-entry buffer, so the block keeps taking requests while results wait.
// A request is taken only when at most two entries are in use. Neither memory
// is cleared and no clearing pass is run.
module column_post_sprite_blitter #(
   parameter int SCREEN_W = cpsb_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = cpsb_pkg::SCREEN_H_DEF
) (
   input logic clock,
   input logic reset,
   cpsb_req_if.sink req,
   cpsb_rsp_if.source rsp
);
   localparam int FB_SIZE = SCREEN_W * SCREEN_H;
   localparam int FBA = $clog2(FB_SIZE);
   localparam int CW = $clog2(SCREEN_W + 3);
   localparam int RW = $clog2(SCREEN_H + 512);
   localparam int XW = $clog2(SCREEN_W + 1);
   localparam int YW = $clog2(SCREEN_H);

   localparam logic [2:0] S_ACC = 3'd0;
   localparam logic [2:0] S_RD = 3'd1;
   localparam logic [2:0] S_TR = 3'd2;
   localparam logic [2:0] S_SH1 = 3'd3;
   localparam logic [2:0] S_SH2 = 3'd4;
   localparam logic [2:0] S_ST = 3'd5;

   logic [7:0] fb_mem [FB_SIZE];
   logic [7:0] tint_mem [65536];
   logic [7:0] fb_rd_ff, tint_rd_ff;

   logic [2:0] st_ff, st_in;
   logic [2:0] ph_ff, ph_in;
   logic [7:0] left_ff, left_in;
   logic [8:0] prow_ff, prow_in;
   logic [XW-1:0] col_ff, col_in;
   logic [XW-1:0] ox_ff, ox_in;
   logic [YW-1:0] oy_ff, oy_in;
   logic [XW-1:0] ctot_ff, ctot_in;
   logic [1:0] dm_ff, dm_in;
   cpsb_pkg::req_type r_ff;
   logic [FBA-1:0] a_ff, a2_ff;
   logic pon_ff;
   logic signed [17:0] x_ff, y_ff;

   logic fb_we, fb_re, t_re;
   logic [FBA-1:0] fb_wa, fb_ra;
   logic [7:0] fb_wd;
   logic [15:0] t_ra;
   logic push;
   cpsb_pkg::rsp_type pd;
   logic [2:0] cnt;

   cpsb_fifo u_fifo (.clock, .reset, .push, .push_data(pd), .count(cnt), .rsp);

   always_ff @(posedge clock) begin
      if (fb_we) fb_mem[fb_wa] <= fb_wd;
      if (fb_re) fb_rd_ff <= fb_mem[fb_ra];
      if (req.valid && req.ready && req.data.op == cpsb_pkg::OP_TINT)
         tint_mem[req.data.address] <= req.data.data_byte;
      if (t_re) tint_rd_ff <= tint_mem[t_ra];
   end

   // current pixel geometry
   logic [RW-1:0] row, row2;
   logic [CW-1:0] colp, col2;
   logic on, on2;
   logic [FBA-1:0] pa, pa2;
   always_comb begin
      row = RW'(oy_ff) + RW'(prow_ff);
      colp = CW'(ox_ff) + CW'(col_ff);
      row2 = row + RW'(2);
      col2 = colp + CW'(2);
      on = row < RW'(SCREEN_H) && colp < CW'(SCREEN_W);
      on2 = row2 < RW'(SCREEN_H) && col2 < CW'(SCREEN_W);
      pa = FBA'(row * SCREEN_W) + FBA'(colp);
      pa2 = FBA'(row2 * SCREEN_W) + FBA'(col2);
   end

   assign req.ready = !reset && st_ff == S_ACC && cnt <= 3'd2;

   always_comb begin
      logic [2:0] op;
      logic [7:0] b;
      st_in = st_ff; ph_in = ph_ff; left_in = left_ff; prow_in = prow_ff;
      col_in = col_ff; ox_in = ox_ff; oy_in = oy_ff; ctot_in = ctot_ff; dm_in = dm_ff;
      fb_we = 1'b0; fb_re = 1'b0; t_re = 1'b0;
      fb_wa = pa; fb_ra = pa; fb_wd = '0; t_ra = '0;
      push = 1'b0;
      pd = '{kind: cpsb_pkg::KIND_WRITE, pixel_address: 16'(pa), pixel_value: 8'd0,
             last: 1'b1};
      op = req.data.op;
      b = req.data.data_byte;
      case (st_ff)
         S_ACC: if (req.valid && req.ready) begin
            case (op)
               cpsb_pkg::OP_START: st_in = S_ST;
               cpsb_pkg::OP_WRITE: if (32'(req.data.address) < FB_SIZE) begin
                  fb_we = 1'b1; fb_wa = FBA'(req.data.address); fb_wd = b;
                  push = 1'b1; pd.pixel_address = req.data.address; pd.pixel_value = b;
               end
               cpsb_pkg::OP_READ: begin
                  fb_re = 1'b1; fb_ra = FBA'(req.data.address); st_in = S_RD;
               end
               cpsb_pkg::OP_COLUMN: begin
                  case (ph_ff)
                     cpsb_pkg::PH_TOP: if (b == cpsb_pkg::END_MARK) begin
                        col_in = col_ff + XW'(1);
                        if (col_in >= ctot_ff) ph_in = cpsb_pkg::PH_IDLE;
                     end else begin
                        prow_in = {1'b0, b}; ph_in = cpsb_pkg::PH_LEN;
                     end
                     cpsb_pkg::PH_LEN: begin left_in = b; ph_in = cpsb_pkg::PH_PADA; end
                     cpsb_pkg::PH_PADA:
                        ph_in = left_ff != 8'd0 ? cpsb_pkg::PH_PIX : cpsb_pkg::PH_PADB;
                     cpsb_pkg::PH_PADB: ph_in = cpsb_pkg::PH_TOP;
                     cpsb_pkg::PH_PIX: begin
                        if (dm_ff == cpsb_pkg::MODE_SHADOW && on2) begin
                           fb_re = 1'b1; fb_ra = pa2; st_in = S_SH1;
                        end else if (dm_ff == cpsb_pkg::MODE_TRANS && on) begin
                           fb_re = 1'b1; st_in = S_RD;
                        end else begin
                           if (on) begin
                              fb_we = 1'b1; fb_wd = b; push = 1'b1; pd.pixel_value = b;
                           end
                           prow_in = prow_ff + 9'd1; left_in = left_ff - 8'd1;
                           if (left_in == 8'd0) ph_in = cpsb_pkg::PH_PADB;
                        end
                     end
                     default: ph_in = cpsb_pkg::PH_IDLE;
                  endcase
               end
               default: ;
            endcase
         end
         S_RD: begin
            if (r_ff.op == cpsb_pkg::OP_READ) begin
               push = 1'b1; pd.kind = cpsb_pkg::KIND_READ;
               pd.pixel_address = r_ff.address;
               pd.pixel_value = 32'(r_ff.address) < FB_SIZE ? fb_rd_ff : 8'd0;
               st_in = S_ACC;
            end else begin
               t_re = 1'b1; t_ra = {fb_rd_ff, r_ff.data_byte}; st_in = S_TR;
            end
         end
         S_TR: begin
            // shadowed mode copies the source byte, translucent writes the tint
            fb_we = 1'b1; fb_wa = a_ff;
            fb_wd = dm_ff == cpsb_pkg::MODE_SHADOW ? r_ff.data_byte : tint_rd_ff;
            push = 1'b1; pd.pixel_address = 16'(a_ff); pd.pixel_value = fb_wd;
            prow_in = prow_ff + 9'd1; left_in = left_ff - 8'd1;
            if (left_in == 8'd0) ph_in = cpsb_pkg::PH_PADB;
            st_in = S_ACC;
         end
         S_SH1: begin
            t_re = 1'b1; t_ra = {fb_rd_ff, 8'd0}; st_in = S_SH2;
         end
         S_SH2: begin
            fb_we = 1'b1; fb_wa = a2_ff; fb_wd = tint_rd_ff;
            push = 1'b1; pd.pixel_address = 16'(a2_ff); pd.pixel_value = tint_rd_ff;
            pd.last = !pon_ff;
            st_in = S_ACC;
            if (pon_ff) begin
               st_in = S_TR;
            end else begin
               prow_in = prow_ff + 9'd1; left_in = left_ff - 8'd1;
               if (left_in == 8'd0) ph_in = cpsb_pkg::PH_PADB;
            end
         end
         S_ST: begin
            st_in = S_ACC;
            if (x_ff < 0 || x_ff + 18'(r_ff.patch_width) > 18'(SCREEN_W) ||
                y_ff < 0 || y_ff + 18'(r_ff.patch_height) > 18'(SCREEN_H)) begin
               ph_in = cpsb_pkg::PH_IDLE;
               push = 1'b1; pd.kind = cpsb_pkg::KIND_BAD; pd.pixel_address = '0;
            end else begin
               ox_in = XW'(x_ff); oy_in = YW'(y_ff); ctot_in = XW'(r_ff.patch_width);
               col_in = '0; prow_in = '0; left_in = '0; dm_in = r_ff.mode;
               ph_in = r_ff.patch_width != 15'd0 ? cpsb_pkg::PH_TOP : cpsb_pkg::PH_IDLE;
            end
         end
         default: st_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         r_ff <= req.data;
         a_ff <= pa;
         a2_ff <= pa2;
         pon_ff <= on;
         x_ff <= 18'(req.data.pos_x) - 18'(req.data.left_offset);
         y_ff <= 18'(req.data.pos_y) - 18'(req.data.top_offset);
      end
      if (reset) begin
         st_ff <= S_ACC; ph_ff <= cpsb_pkg::PH_IDLE; left_ff <= '0; prow_ff <= '0;
         col_ff <= '0; ox_ff <= '0; oy_ff <= '0; ctot_ff <= '0; dm_ff <= '0;
      end else begin
         st_ff <= st_in;
         ph_ff <= ph_in;
         left_ff <= left_in; prow_ff <= prow_in; col_ff <= col_in;
         ox_ff <= ox_in; oy_ff <= oy_in; ctot_ff <= ctot_in; dm_ff <= dm_in;
      end
   end
endmodule

// ----- verif/tb_column_post_sprite_blitter.sv -----
`timescale 1ns / 1ps

module tb_column_post_sprite_blitter;

   localparam int SW = cpsb_pkg::SCREEN_W_DEF;
   localparam int SH = cpsb_pkg::SCREEN_H_DEF;
   localparam int FB_WORDS = SW * SH;
   // sprites stay in a preloaded box at the lower left, pixel values stay small
   localparam int BW = 20;
   localparam int BH = 20;
   localparam int NV = 4;
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic clock;
   logic reset;

   cpsb_req_if req_ch ();
   cpsb_rsp_if rsp_ch ();

   column_post_sprite_blitter u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // predictor state
   logic [7:0] fb_mirror [FB_WORDS];
   logic [7:0] tint_mirror [65536];
   logic [2:0] ph;
   logic [7:0] px_left;
   logic [8:0] prow;
   int cidx, ox, oy, ctot;
   logic [1:0] dmode;

   cpsb_pkg::rsp_type pixel_q [$];
   cpsb_pkg::req_type pend_q [$];
   bit hold_q [$];

   int mismatches = 0;
   int cyc = 0;
   int n_wr = 0, n_rd = 0, n_bad = 0, n_sprites = 0;
   bit took = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   task automatic put(ref cpsb_pkg::rsp_type tmp [$], input logic [1:0] k,
                      input int a, input logic [7:0] v);
      cpsb_pkg::rsp_type e;
      e.kind = k;
      e.pixel_address = a[15:0];
      e.pixel_value = v;
      e.last = 1'b0;
      tmp.push_back(e);
   endtask

   task automatic draw(input logic [7:0] src, ref cpsb_pkg::rsp_type tmp [$]);
      int row, col, a;
      logic [7:0] v;
      row = oy + int'(prow);
      col = ox + cidx;
      if (dmode == cpsb_pkg::MODE_SHADOW && row + 2 < SH && col + 2 < SW) begin
         a = (row + 2) * SW + col + 2;
         v = tint_mirror[{fb_mirror[a], 8'h00}];
         fb_mirror[a] = v;
         put(tmp, cpsb_pkg::KIND_WRITE, a, v);
      end
      if (row < SH && col < SW) begin
         a = row * SW + col;
         v = src;
         if (dmode == cpsb_pkg::MODE_TRANS) v = tint_mirror[{fb_mirror[a], src}];
         fb_mirror[a] = v;
         put(tmp, cpsb_pkg::KIND_WRITE, a, v);
      end
   endtask

   task automatic predict(input cpsb_pkg::req_type r);
      cpsb_pkg::rsp_type tmp [$];
      int x, y, w, h;
      case (r.op)
         cpsb_pkg::OP_START: begin
            x = int'($signed(r.pos_x)) - int'($signed(r.left_offset));
            y = int'($signed(r.pos_y)) - int'($signed(r.top_offset));
            w = int'(r.patch_width);
            h = int'(r.patch_height);
            if (x < 0 || x + w > SW || y < 0 || y + h > SH) begin
               ph = cpsb_pkg::PH_IDLE;
               put(tmp, cpsb_pkg::KIND_BAD, 0, 8'h00);
            end else begin
               ox = x; oy = y; ctot = w; cidx = 0; prow = 0; px_left = 0;
               dmode = r.mode;
               ph = (w != 0) ? cpsb_pkg::PH_TOP : cpsb_pkg::PH_IDLE;
            end
         end
         cpsb_pkg::OP_COLUMN: begin
            case (ph)
               cpsb_pkg::PH_TOP: begin
                  if (r.data_byte == cpsb_pkg::END_MARK) begin
                     cidx++;
                     if (cidx >= ctot) ph = cpsb_pkg::PH_IDLE;
                  end else begin
                     prow = {1'b0, r.data_byte};
                     ph = cpsb_pkg::PH_LEN;
                  end
               end
               cpsb_pkg::PH_LEN: begin
                  px_left = r.data_byte;
                  ph = cpsb_pkg::PH_PADA;
               end
               cpsb_pkg::PH_PADA: ph = (px_left != 0) ? cpsb_pkg::PH_PIX : cpsb_pkg::PH_PADB;
               cpsb_pkg::PH_PIX: begin
                  draw(r.data_byte, tmp);
                  prow = prow + 9'd1;
                  px_left = px_left - 8'd1;
                  if (px_left == 0) ph = cpsb_pkg::PH_PADB;
               end
               cpsb_pkg::PH_PADB: ph = cpsb_pkg::PH_TOP;
               default: ph = cpsb_pkg::PH_IDLE;
            endcase
         end
         cpsb_pkg::OP_WRITE: begin
            if (int'(r.address) < FB_WORDS) begin
               fb_mirror[r.address] = r.data_byte;
               put(tmp, cpsb_pkg::KIND_WRITE, int'(r.address), r.data_byte);
            end
         end
         cpsb_pkg::OP_READ:
            put(tmp, cpsb_pkg::KIND_READ, int'(r.address),
                int'(r.address) < FB_WORDS ? fb_mirror[r.address] : 8'h00);
         cpsb_pkg::OP_TINT: tint_mirror[r.address] = r.data_byte;
         default: ;
      endcase
      if (tmp.size() > 0) tmp[$].last = 1'b1;
      foreach (tmp[i]) pixel_q.push_back(tmp[i]);
   endtask

   function automatic logic [15:0] box_addr();
      int row, col;
      row = SH - BH + int'($urandom_range(0, BH - 1));
      col = int'($urandom_range(0, BW - 1));
      return 16'(row * SW + col);
   endfunction

   function automatic cpsb_pkg::req_type noise_req();
      logic [127:0] bits;
      cpsb_pkg::req_type r;
      bits = {$urandom, $urandom, $urandom, $urandom};
      r = bits[$bits(cpsb_pkg::req_type)-1:0];
      case (r.op)
         cpsb_pkg::OP_START: r.patch_width[14] = 1'b1;   // always off screen
         cpsb_pkg::OP_COLUMN, cpsb_pkg::OP_WRITE, cpsb_pkg::OP_TINT:
            r.data_byte = 8'($urandom_range(0, NV - 1));
         cpsb_pkg::OP_READ:
            r.address = ($urandom_range(0, 7) == 0) ?
                        16'(FB_WORDS + int'($urandom_range(0, 65535 - FB_WORDS))) :
                        box_addr();
         default: ;
      endcase
      return r;
   endfunction

   task automatic send(input cpsb_pkg::req_type r, input bit hold = 0);
      pend_q.push_back(r);
      hold_q.push_back(hold);
   endtask

   task automatic send_op(input logic [2:0] op, input int a, input int d);
      cpsb_pkg::req_type r;
      r = noise_req();
      r.op = op;
      r.address = a[15:0];
      r.data_byte = d[7:0];
      send(r);
   endtask

   task automatic send_start(input int x, input int y, input int w, input int h,
                             input logic [1:0] m);
      cpsb_pkg::req_type r;
      int lo, to;
      r = noise_req();
      lo = int'($urandom_range(0, 32000)) - 16000;
      to = int'($urandom_range(0, 32000)) - 16000;
      r.op = cpsb_pkg::OP_START;
      r.pos_x = 16'(x + lo);
      r.left_offset = 16'(lo);
      r.pos_y = 16'(y + to);
      r.top_offset = 16'(to);
      r.patch_width = 15'(w);
      r.patch_height = 15'(h);
      r.mode = m;
      send(r);
   endtask

   task automatic send_col(input int b);
      send_op(cpsb_pkg::OP_COLUMN, $urandom, b);
   endtask

   task automatic send_post(input int top, input int len);
      send_col(top);
      send_col(len);
      send_col($urandom);
      repeat (len) send_col($urandom_range(0, NV - 1));
      send_col($urandom);
   endtask

   task automatic send_sprite();
      int w, h, x, y, posts, top, len;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      h = $urandom_range(1, BH);
      x = $urandom_range(0, BW - 2 - w);
      y = $urandom_range(SH - BH, SH - h);
      send_start(x, y, w, h, 2'($urandom_range(0, 3)));
      for (int c = 0; c < w; c++) begin
         if ($urandom_range(0, 29) == 0) return; // abandon mid-patch
         posts = $urandom_range(0, 3);
         repeat (posts) begin
            top = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 254)
                                              : $urandom_range(0, h);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40)
                                               : $urandom_range(0, 6);
            send_post(top, len);
         end
         send_col(cpsb_pkg::END_MARK);
      end
   endtask

   // driver
   always @(negedge clock) begin
      bit calm, idle;
      cyc++;
      calm = cyc >= 1200 && cyc < 1800;
      idle = !calm && ($urandom_range(0, 99) < 11);
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
         if (req_ch.valid && !took) begin
            // hold current request
         end else if (pend_q.size() > 0 && !idle &&
                      (!hold_q[0] || pixel_q.size() == 0)) begin
            req_ch.data <= pend_q.pop_front();
            void'(hold_q.pop_front());
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cpsb_pkg::rsp_type e;
      took = !reset && req_ch.valid && req_ch.ready;
      if (took) predict(req_ch.data);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d addr=%0d val=%0d last=%0b",
                        rsp_ch.data.kind, rsp_ch.data.pixel_address,
                        rsp_ch.data.pixel_value, rsp_ch.data.last);
         end else begin
            e = pixel_q.pop_front();
            case (e.kind)
               cpsb_pkg::KIND_WRITE: n_wr++;
               cpsb_pkg::KIND_READ: n_rd++;
               default: n_bad++;
            endcase
            if (rsp_ch.data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch exp kind=%0d addr=%0d val=%0d last=%0b,",
                            " got kind=%0d addr=%0d val=%0d last=%0b"},
                           e.kind, e.pixel_address, e.pixel_value, e.last,
                           rsp_ch.data.kind, rsp_ch.data.pixel_address,
                           rsp_ch.data.pixel_value, rsp_ch.data.last);
            end
         end
      end
   end

   initial begin
      cpsb_pkg::req_type r;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // load every tint entry and box pixel that a lookup can reach
      for (int d = 0; d < NV; d++)
         for (int s = 0; s < NV; s++)
            send_op(cpsb_pkg::OP_TINT, d * 256 + s, $urandom_range(0, NV - 1));
      for (int row = SH - BH; row < SH; row++)
         for (int col = 0; col < BW; col++)
            send_op(cpsb_pkg::OP_WRITE, row * SW + col, $urandom_range(0, NV - 1));

      // directed
      send_op(cpsb_pkg::OP_WRITE, 0, 8'hff);
      send_op(cpsb_pkg::OP_WRITE, FB_WORDS - 1, 8'h00);
      send_op(cpsb_pkg::OP_WRITE, FB_WORDS, 8'h55);
      send_op(cpsb_pkg::OP_READ, FB_WORDS - 1, 0);
      send_op(cpsb_pkg::OP_READ, 65535, 0);
      send_op(cpsb_pkg::OP_TINT, 65535, 8'haa);
      send_op(OP_SPARE_A, 100, 1);
      send_op(OP_SPARE_B, 100, 1);
      send_col(8'h10);                     // column byte while idle
      send_start(-1, 0, 1, 1, cpsb_pkg::MODE_OPAQUE);  // left of screen
      send_col(0);                         // ignored after bad placement
      send_start(SW - 1, 0, 2, 1, cpsb_pkg::MODE_OPAQUE);
      send_start(0, SH - 4, 1, 5, cpsb_pkg::MODE_OPAQUE);
      r = noise_req();
      r.op = cpsb_pkg::OP_START; r.pos_x = 16'sh7fff; r.left_offset = 16'sh8000;
      send(r);
      send_start(5, 5, 0, 3, cpsb_pkg::MODE_OPAQUE);   // zero width
      send_start(SW - 2, SH - 3, 2, 3, cpsb_pkg::MODE_SHADOW);
      send_post(0, 3);
      send_post(1, 0);                     // zero-length post
      send_col(cpsb_pkg::END_MARK);
      send_post(250, 3);                   // runs off bottom
      send_col(cpsb_pkg::END_MARK);
      send_start(2, SH - 10, 3, 10, cpsb_pkg::MODE_TRANS);
      send_post(2, 2);
      send_start(20, 20, 1, 4, MODE_SPARE);  // mid-patch restart, mode three
      send_post(0, 4);
      send_col(cpsb_pkg::END_MARK);
      hold_q[$] = 1'b1;                    // wait for all results before it

      // random
      while (pend_q.size() < 1800) begin
         if ($urandom_range(0, 3) != 0) begin
            send_sprite();
            n_sprites++;
         end else begin
            send(noise_req());
         end
      end

      while (pend_q.size() > 0 || req_ch.valid) @(posedge clock);
      while (pixel_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      mismatches += pixel_q.size();
      $display("covered %0d sprites plus noise: %0d writes, %0d reads, %0d bad placements",
               n_sprites, n_wr, n_rd, n_bad);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout");
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/cpsb_pkg.sv
src/cpsb_if.sv
src/cpsb_fifo.sv
src/column_post_sprite_blitter.sv
verif/tb_column_post_sprite_blitter.sv
